// File: rtl/usart_pkg.sv
// Shared types and codes for the USART register block.
// Operation, register, timer-command and interrupt codes; result struct.
// No dependencies.
package usart_pkg;

    typedef enum logic [2:0] {
        FUNC_READ      = 3'd0,
        FUNC_WRITE     = 3'd1,
        FUNC_TX_DONE   = 3'd2,
        FUNC_BRK_TICK  = 3'd3,
        FUNC_LB_RECV   = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        SEL_UCR = 2'd0,
        SEL_RSR = 2'd1,
        SEL_TSR = 2'd2,
        SEL_UDR = 2'd3
    } reg_sel_t;

    typedef enum logic [2:0] {
        TCMD_NONE       = 3'd0,
        TCMD_WORD_START = 3'd1,
        TCMD_BRK_START  = 3'd2,
        TCMD_BRK_STOP   = 3'd3,
        TCMD_BRK_STOP_TX = 3'd4
    } timer_cmd_t;

    localparam logic [3:0] IRQ_RX_FULL  = 4'b0001;
    localparam logic [3:0] IRQ_RX_ERR   = 4'b0010;
    localparam logic [3:0] IRQ_TX_EMPTY = 4'b0100;
    localparam logic [3:0] IRQ_TX_ERR   = 4'b1000;

    localparam logic [3:0] BPW_RESET = 4'd8;
    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 5;
    localparam int OUT_TDATA_W = 32;

    typedef struct packed {
        logic [3:0] frame_bits;
        logic       baud_recalc;
        logic [2:0] timer_cmd;
        logic [7:0] out_byte;
        logic       loopback_valid;
        logic       tx_out_valid;
        logic [3:0] irq_mask;
        logic [7:0] read_data;
    } result_t;

endpackage

// File: rtl/usart_regs.sv
// USART register file: UCR, RSR, TSR, UDR, overrun flag and frame length.
// Computes one result per accepted transfer combinationally; uses usart_pkg.
module usart_regs
    import usart_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_bit,
    input  logic       op_accept,
    input  logic [2:0] op_func,
    input  logic [1:0] op_sel,
    input  logic [7:0] op_data,
    output result_t    op_result
);

    logic [7:0] ucr_reg, ucr_next;
    logic [7:0] rsr_reg, rsr_next;
    logic [7:0] tsr_reg, tsr_next;
    logic [7:0] rxd_reg, rxd_next;
    logic       ovr_reg, ovr_next;
    logic [3:0] bpw_reg, bpw_next;
    logic       err_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ucr_reg    <= '0;
            rsr_reg    <= '0;
            tsr_reg    <= '0;
            rxd_reg    <= '0;
            ovr_reg    <= 1'b0;
            bpw_reg    <= BPW_RESET;
            err_en_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                err_en_reg <= cfg_bit;
            end
            if (op_accept) begin
                ucr_reg <= ucr_next;
                rsr_reg <= rsr_next;
                tsr_reg <= tsr_next;
                rxd_reg <= rxd_next;
                ovr_reg <= ovr_next;
                bpw_reg <= bpw_next;
            end
        end
    end

    always_comb begin
        logic [3:0] nb;
        logic [7:0] v;
        result_t    r;

        ucr_next = ucr_reg;
        rsr_next = rsr_reg;
        tsr_next = tsr_reg;
        rxd_next = rxd_reg;
        ovr_next = ovr_reg;
        bpw_next = bpw_reg;
        r        = '0;
        nb       = 4'd10 - {2'b00, op_data[6:5]} + {3'b000, op_data[4]};
        v        = op_data;

        case (func_t'(op_func))
            FUNC_READ: begin
                case (reg_sel_t'(op_sel))
                    SEL_UCR: r.read_data = ucr_reg;
                    SEL_RSR: begin
                        if (!ovr_reg) begin
                            rsr_next[6] = 1'b0;
                        end
                        r.read_data = rsr_next;
                    end
                    SEL_TSR: begin
                        tsr_next[6] = 1'b0;
                        r.read_data = tsr_next;
                    end
                    default: begin
                        rsr_next[7] = 1'b0;
                        if (ovr_reg) begin
                            ovr_next   = 1'b0;
                            r.irq_mask = err_en_reg ? IRQ_RX_ERR : IRQ_RX_FULL;
                        end
                        r.read_data = rxd_reg;
                    end
                endcase
            end
            FUNC_WRITE: begin
                case (reg_sel_t'(op_sel))
                    SEL_UCR: begin
                        r.baud_recalc = (ucr_reg[7] != op_data[7]) || (nb != bpw_reg);
                        bpw_next      = nb;
                        ucr_next      = {op_data[7:1], 1'b0};
                    end
                    SEL_RSR: begin
                        if (!op_data[0] && rsr_reg[0]) begin
                            v = '0;
                        end
                        rsr_next = {rsr_reg[7], v[6:0]};
                    end
                    SEL_TSR: begin
                        if (op_data[0] && !tsr_reg[0]) begin
                            v[4] = 1'b0;
                        end
                        tsr_next = {tsr_reg[7], v[6:0]};
                        if (v[3] != tsr_reg[3]) begin
                            if (v[3]) begin
                                r.timer_cmd = TCMD_BRK_START;
                            end else if (!tsr_reg[7]) begin
                                r.timer_cmd = TCMD_BRK_STOP_TX;
                            end else begin
                                r.timer_cmd = TCMD_BRK_STOP;
                            end
                        end
                    end
                    default: begin
                        if (tsr_reg[0] && !tsr_reg[3]) begin
                            tsr_next[7] = 1'b0;
                            r.timer_cmd = TCMD_WORD_START;
                            if (tsr_reg[2:1] == 2'b11) begin
                                r.loopback_valid = 1'b1;
                                r.out_byte       = op_data;
                            end else begin
                                r.tx_out_valid = 1'b1;
                                r.out_byte     = op_data & (8'hFF >> ucr_reg[6:5]);
                            end
                        end
                    end
                endcase
            end
            FUNC_TX_DONE: begin
                tsr_next[7] = 1'b1;
                r.irq_mask  = IRQ_TX_EMPTY;
                if (!tsr_reg[0]) begin
                    tsr_next[4] = 1'b1;
                    r.irq_mask  = IRQ_TX_EMPTY | IRQ_TX_ERR;
                    if (tsr_reg[5]) begin
                        rsr_next[0] = 1'b1;
                    end
                end
            end
            FUNC_BRK_TICK: begin
                if (tsr_reg[3]) begin
                    if (!tsr_reg[6]) begin
                        r.irq_mask = IRQ_TX_ERR;
                    end
                    r.timer_cmd = TCMD_BRK_START;
                end
            end
            FUNC_LB_RECV: begin
                if (rsr_reg[0]) begin
                    if (!rsr_reg[7]) begin
                        rxd_next = op_data;
                        ovr_next = 1'b0;
                    end else begin
                        ovr_next = 1'b1;
                    end
                    rsr_next   = {1'b1, rsr_reg[6], 4'b0000, rsr_reg[1:0]};
                    r.irq_mask = IRQ_RX_FULL;
                end
            end
            default: ;
        endcase

        r.frame_bits = bpw_next;
        op_result    = r;
    end

endmodule

// File: rtl/usart_out_stage.sv
// Result register of the USART register block.
// Holds one result until the master side takes it; uses usart_pkg.
module usart_out_stage
    import usart_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  result_t                load_data,
    output logic                   free,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    logic    valid_reg;
    result_t data_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, data_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

endmodule

// File: rtl/usart_register_block.sv
// USART register block, top level.
// Instantiates usart_regs and usart_out_stage; uses usart_pkg.
//
// Usage:
//   s_ channel: one transfer per register access or event.
//     s_tuser carries the operation and register select, s_tdata the byte.
//   m_ channel: exactly one result transfer per input transfer, in order.
//   cfg_ channel: writes the receive-error interrupt enable bit; always ready.
//     Write it only while no transfers are in flight.
// Output: each result is registered and appears on m_ in the cycle after its input transfer.
// Throughput: one transfer per cycle; the only storage on the path is the
//   result register, so a held result blocks s_tready only while m_tready
//   is low.
// Stall: with m_tready low the result register holds its value and s_tready
//   drops; register state changes only on accepted transfers.
// Reset: aresetn low clears all registers and the enable bit, sets frame
//   length to 8 and empties the result register.
module usart_register_block
    import usart_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] write_data
    input  logic [IN_TUSER_W-1:0]  s_tuser,   // [2:0] func, [4:3] reg_sel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] read_data, [11:8] irq_mask, [12] tx_out_valid, [13] loopback_valid,
    // [21:14] out_byte, [24:22] timer_cmd, [25] baud_recalc, [29:26] frame_bits
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_data
);

    logic    accept;
    logic    stage_free;
    result_t result;

    assign s_tready  = stage_free;
    assign accept    = s_tvalid && stage_free;
    assign cfg_ready = 1'b1;

    usart_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid),
        .cfg_bit   (cfg_data),
        .op_accept (accept),
        .op_func   (s_tuser[2:0]),
        .op_sel    (s_tuser[4:3]),
        .op_data   (s_tdata),
        .op_result (result)
    );

    usart_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept),
        .load_data (result),
        .free      (stage_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
